@@ rtl/core/sndc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sndc_pkg: shared types and constants for the strided copy address generator
// Holds the transaction structs, the command codes, the sizes and the state
// enum used by the cell chain and the top level.
// ----------------------------------------------------------------------------
package sndc_pkg;

    localparam int MAX_RANK    = 16;
    localparam int ADDR_WIDTH  = 48;
    localparam int COUNT_WIDTH = 32;
    localparam int DIM_W       = 4;
    localparam int RANK_W      = 5;
    localparam int EB_W        = 7;
    localparam int EXT_W       = 32;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_NEXT  = 2'd2;

    typedef struct packed {
        logic [1:0]             cmd;
        logic [DIM_W-1:0]       dim_index;
        logic [EXT_W-1:0]       extent;
        logic signed [31:0]     src_step;
        logic signed [31:0]     dst_step;
        logic [RANK_W-1:0]      src_rank;
        logic [RANK_W-1:0]      dst_rank;
        logic [ADDR_WIDTH-1:0]  src_base;
        logic [ADDR_WIDTH-1:0]  dst_base;
        logic signed [31:0]     src_offset;
        logic signed [31:0]     dst_offset;
        logic [EB_W-1:0]        elem_bytes;
    } in_item_t;

    typedef struct packed {
        logic                   element_valid;
        logic [ADDR_WIDTH-1:0]  src_addr;
        logic [ADDR_WIDTH-1:0]  dst_addr;
        logic [EB_W-1:0]        copy_bytes;
        logic                   last;
        logic                   refused;
        logic [COUNT_WIDTH-1:0] mismatch_count;
        logic [RANK_W-1:0]      first_bad_src_rank;
        logic [RANK_W-1:0]      first_bad_dst_rank;
    } out_item_t;

    // Per-cell control, the same for every cell of the chain.
    typedef struct packed {
        logic             load;
        logic [DIM_W-1:0] load_dim;
        logic             clear;
        logic             step;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_SCALE,
        ST_OUT
    } state_t;

endpackage

@@ rtl/core/sndc_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sndc_cell: one dimension of the copy
// Holds a dimension's extent, strides and index counter. Every cycle it adds
// its counter times stride to the partial offsets from its lower neighbour
// and registers the sums on their way to the next cell. It also resolves
// the carry for stepping.
// ----------------------------------------------------------------------------
module sndc_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [sndc_pkg::DIM_W-1:0] my_dim,
    input  sndc_pkg::cell_ctl_t        ctl,
    input  logic [31:0]                ld_extent,
    input  logic [31:0]                ld_src_stride,
    input  logic [31:0]                ld_dst_stride,
    input  logic                       used,
    input  logic [63:0]                src_in,
    input  logic [63:0]                dst_in,
    output logic [63:0]                src_out,
    output logic [63:0]                dst_out,
    input  logic                       carry_in,
    output logic                       carry_out,
    output logic                       zero_extent
);

    logic [31:0] extent_reg;
    logic [31:0] sstride_reg;
    logic [31:0] dstride_reg;
    logic [31:0] count_reg;
    logic [31:0] count_next;
    logic [63:0] src_prod;
    logic [63:0] dst_prod;
    logic [63:0] src_sum;
    logic [63:0] dst_sum;
    logic        wrap;

    // Dimension table entry, written by a load transaction.
    always_ff @(posedge clk)
    begin
        if (ctl.load && ctl.load_dim == my_dim)
        begin
            extent_reg  <= ld_extent;
            sstride_reg <= ld_src_stride;
            dstride_reg <= ld_dst_stride;
        end
    end

    // Counter times stride for this dimension, masked when the cell is unused.
    always_comb
    begin
        src_prod = {32'd0, count_reg} * {{32{sstride_reg[31]}}, sstride_reg};
        dst_prod = {32'd0, count_reg} * {{32{dstride_reg[31]}}, dstride_reg};
        src_sum  = used ? src_in + src_prod : src_in;
        dst_sum  = used ? dst_in + dst_prod : dst_in;
    end

    // The partial offsets are registered before they reach the next cell.
    always_ff @(posedge clk)
    begin
        src_out <= src_sum;
        dst_out <= dst_sum;
    end

    // The carry ripples from the fastest dimension downwards.
    always_comb
    begin
        wrap        = ({1'b0, count_reg} + 33'd1) >= {1'b0, extent_reg};
        carry_out   = used ? (carry_in && wrap) : carry_in;
        zero_extent = used && (extent_reg == 32'd0);
        count_next  = count_reg;
        if (used && carry_in)
        begin
            count_next = wrap ? 32'd0 : count_reg + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctl.clear)
        begin
            count_reg <= '0;
        end
        else if (ctl.step)
        begin
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/core/strided_nd_copy_address_generator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strided_nd_copy_address_generator: N-dimensional strided copy addresses
// Top level: command decode, status, the chain of dimension cells and the
// result register.
// ----------------------------------------------------------------------------
// A load, a refused start, an unknown command or a next request without an
// active copy writes its result register straight from the decode state
// ST_SUM; an accepted start goes on through ST_OUT. A next request with an
// active copy waits in ST_SUM while the offsets settle through the registered
// chain of dimension cells (each cell adds counter times stride and registers
// the sum for its neighbour), then ST_SCALE scales by the element size and
// ST_OUT adds the start addresses before the result is registered. One
// transaction is in work at a time; the input is ready again once the result
// register is empty or is being taken in the same cycle, so a new
// transaction is not accepted before the last one has finished.
module strided_nd_copy_address_generator (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sndc_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sndc_pkg::out_item_t  out_data
);

    localparam int NR = sndc_pkg::MAX_RANK;
    localparam int AW = sndc_pkg::ADDR_WIDTH;
    localparam int CW = sndc_pkg::COUNT_WIDTH;

    sndc_pkg::state_t    state_reg, state_next;
    sndc_pkg::in_item_t  item_reg;
    sndc_pkg::cell_ctl_t ctl;
    sndc_pkg::out_item_t res_reg, res_next;
    logic                res_valid_reg, res_valid_next;

    logic [AW-1:0]                src_start_reg, dst_start_reg;
    logic [sndc_pkg::RANK_W-1:0]  rank_reg;
    logic [sndc_pkg::EB_W-1:0]    eb_reg;
    logic                         active_reg;
    logic [CW-1:0]                rcount_reg;
    logic [sndc_pkg::RANK_W-1:0]  bad_src_reg, bad_dst_reg;
    logic [sndc_pkg::RANK_W-1:0]  sum_cnt_reg;

    logic [63:0] so_reg, do_reg, ss_reg, ds_reg;
    logic        done_reg;

    logic [63:0] src_ch [0:NR];
    logic [63:0] dst_ch [0:NR];
    logic        carry  [0:NR];
    logic [NR-1:0] zero_ext;

    logic        take;
    logic        start_ok;
    logic        sum_done;
    logic [sndc_pkg::EB_W-1:0]   eb_in;
    logic [sndc_pkg::RANK_W-1:0] rank_in;
    logic [63:0] s_off, d_off;
    logic [63:0] s_start_calc, d_start_calc;
    logic        any_zero;

    assign take      = in_valid && in_ready;
    assign in_ready  = (state_reg == sndc_pkg::ST_IDLE) && !(res_valid_reg && !out_ready);
    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

    // The chain output is settled once every cell has registered its sum.
    assign sum_done  = sum_cnt_reg == sndc_pkg::RANK_W'(NR);

    // Cell chain: slot 0 feeds the lowest dimension, carry enters at the top.
    assign src_ch[0]  = '0;
    assign dst_ch[0]  = '0;
    assign carry[NR]  = 1'b1;

    for (genvar g = 0; g < NR; g++)
    begin : g_cell
        sndc_cell u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .my_dim        (sndc_pkg::DIM_W'(g)),
            .ctl           (ctl),
            .ld_extent     (item_reg.extent),
            .ld_src_stride (item_reg.src_step),
            .ld_dst_stride (item_reg.dst_step),
            .used          ({1'b0, rank_reg} > 6'(g)),
            .src_in        (src_ch[g]),
            .dst_in        (dst_ch[g]),
            .src_out       (src_ch[g+1]),
            .dst_out       (dst_ch[g+1]),
            .carry_in      (carry[g+1]),
            .carry_out     (carry[g]),
            .zero_extent   (zero_ext[g])
        );
    end

    // Start decode on the held transaction.
    always_comb
    begin
        start_ok = item_reg.src_rank == item_reg.dst_rank;
        eb_in    = item_reg.elem_bytes;
        if (eb_in == '0)
        begin
            eb_in = 7'd1;
        end
        else if (eb_in > 7'd64)
        begin
            eb_in = 7'd64;
        end
        rank_in = (item_reg.src_rank > 5'(NR)) ? 5'(NR) : item_reg.src_rank;
        s_off = 64'($signed(item_reg.src_offset)) * {57'd0, eb_in};
        d_off = 64'($signed(item_reg.dst_offset)) * {57'd0, eb_in};
        s_start_calc = {{(64-AW){1'b0}}, item_reg.src_base} + s_off;
        d_start_calc = {{(64-AW){1'b0}}, item_reg.dst_base} + d_off;
    end

    // Zero extent check uses the new rank, so it runs in ST_OUT, after the start decode.
    assign any_zero = |zero_ext;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sndc_pkg::ST_IDLE:
                if (take)
                begin
                    state_next = sndc_pkg::ST_SUM;
                end
            sndc_pkg::ST_SUM:
                if (item_reg.cmd == sndc_pkg::CMD_NEXT && active_reg)
                begin
                    if (sum_done)
                    begin
                        state_next = sndc_pkg::ST_SCALE;
                    end
                end
                else if (item_reg.cmd == sndc_pkg::CMD_START && start_ok)
                begin
                    state_next = sndc_pkg::ST_OUT;
                end
                else
                begin
                    state_next = sndc_pkg::ST_IDLE;
                end
            sndc_pkg::ST_SCALE:
                state_next = sndc_pkg::ST_OUT;
            sndc_pkg::ST_OUT:
                state_next = sndc_pkg::ST_IDLE;
            default:
                state_next = sndc_pkg::ST_IDLE;
        endcase
    end

    // Cell control outputs.
    always_comb
    begin
        ctl          = '0;
        ctl.load_dim = item_reg.dim_index;
        if (state_reg == sndc_pkg::ST_SUM)
        begin
            ctl.load  = item_reg.cmd == sndc_pkg::CMD_LOAD;
            ctl.clear = item_reg.cmd == sndc_pkg::CMD_START && start_ok;
            ctl.step  = item_reg.cmd == sndc_pkg::CMD_NEXT && active_reg && sum_done;
        end
    end

    // Result assembly.
    always_comb
    begin
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !out_ready;
        if (state_reg == sndc_pkg::ST_SUM &&
            !(item_reg.cmd == sndc_pkg::CMD_NEXT && active_reg) &&
            !(item_reg.cmd == sndc_pkg::CMD_START && start_ok))
        begin
            res_valid_next             = 1'b1;
            res_next                   = '0;
            res_next.copy_bytes        = eb_reg;
            res_next.mismatch_count    = rcount_reg;
            res_next.first_bad_src_rank = bad_src_reg;
            res_next.first_bad_dst_rank = bad_dst_reg;
            if (item_reg.cmd == sndc_pkg::CMD_START)
            begin
                res_next.refused = 1'b1;
                if (rcount_reg == '0)
                begin
                    res_next.first_bad_src_rank = item_reg.src_rank;
                    res_next.first_bad_dst_rank = item_reg.dst_rank;
                end
                if (rcount_reg != '1)
                begin
                    res_next.mismatch_count = rcount_reg + CW'(1);
                end
            end
        end
        else if (state_reg == sndc_pkg::ST_OUT)
        begin
            res_valid_next              = 1'b1;
            res_next                    = '0;
            res_next.copy_bytes         = eb_reg;
            res_next.mismatch_count     = rcount_reg;
            res_next.first_bad_src_rank = bad_src_reg;
            res_next.first_bad_dst_rank = bad_dst_reg;
            if (item_reg.cmd == sndc_pkg::CMD_NEXT)
            begin
                res_next.element_valid = 1'b1;
                res_next.src_addr      = src_start_reg + ss_reg[AW-1:0];
                res_next.dst_addr      = dst_start_reg + ds_reg[AW-1:0];
                res_next.last          = done_reg;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sndc_pkg::ST_IDLE;
            res_valid_reg <= 1'b0;
            src_start_reg <= '0;
            dst_start_reg <= '0;
            rank_reg      <= '0;
            eb_reg        <= 7'd1;
            active_reg    <= 1'b0;
            rcount_reg    <= '0;
            bad_src_reg   <= '0;
            bad_dst_reg   <= '0;
            sum_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            if (state_reg == sndc_pkg::ST_SUM && state_next == sndc_pkg::ST_SUM)
            begin
                sum_cnt_reg <= sum_cnt_reg + sndc_pkg::RANK_W'(1);
            end
            else
            begin
                sum_cnt_reg <= '0;
            end
            if (state_reg == sndc_pkg::ST_SUM && item_reg.cmd == sndc_pkg::CMD_START)
            begin
                if (start_ok)
                begin
                    eb_reg        <= eb_in;
                    rank_reg      <= rank_in;
                    src_start_reg <= s_start_calc[AW-1:0];
                    dst_start_reg <= d_start_calc[AW-1:0];
                    active_reg    <= 1'b1;
                end
                else
                begin
                    active_reg <= 1'b0;
                    if (rcount_reg == '0)
                    begin
                        bad_src_reg <= item_reg.src_rank;
                        bad_dst_reg <= item_reg.dst_rank;
                    end
                    if (rcount_reg != '1)
                    begin
                        rcount_reg <= rcount_reg + CW'(1);
                    end
                end
            end
            else if (state_reg == sndc_pkg::ST_SUM && ctl.step && carry[0])
            begin
                active_reg <= 1'b0;
            end
            else if (state_reg == sndc_pkg::ST_OUT &&
                     item_reg.cmd == sndc_pkg::CMD_START && any_zero)
            begin
                active_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (take)
        begin
            item_reg <= in_data;
        end
        if (state_reg == sndc_pkg::ST_SUM)
        begin
            so_reg   <= src_ch[NR];
            do_reg   <= dst_ch[NR];
            done_reg <= carry[0];
        end
        if (state_reg == sndc_pkg::ST_SCALE)
        begin
            ss_reg <= so_reg * {57'd0, eb_reg};
            ds_reg <= do_reg * {57'd0, eb_reg};
        end
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the strided copy address generator
// Drives load, start, next and unknown-command transactions through a
// directed table and then random copies, predicts every result in a local
// model and compares each output transaction as a whole.
// ----------------------------------------------------------------------------
module testbench;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    sndc_pkg::in_item_t  in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    sndc_pkg::out_item_t out_data;

    strided_nd_copy_address_generator DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always #5 clk = ~clk;

    // Predictor state.
    logic [31:0]                      pr_extent  [sndc_pkg::MAX_RANK];
    logic [31:0]                      pr_sstride [sndc_pkg::MAX_RANK];
    logic [31:0]                      pr_dstride [sndc_pkg::MAX_RANK];
    logic [31:0]                      pr_counter [sndc_pkg::MAX_RANK];
    logic [sndc_pkg::ADDR_WIDTH-1:0]  pr_src_start, pr_dst_start;
    int unsigned                      pr_rank;
    logic [sndc_pkg::EB_W-1:0]        pr_eb;
    bit                               pr_active;
    logic [sndc_pkg::COUNT_WIDTH-1:0] pr_refusals;
    logic [sndc_pkg::RANK_W-1:0]      pr_bad_src, pr_bad_dst;

    sndc_pkg::out_item_t expected_results[$];
    int          errors = 0;
    bit          rx_idle_ok = 1'b1;
    bit          rx_long_hold = 1'b0;
    bit          tx_idle_ok = 1'b1;

    // Works out the result of one transaction and advances the predictor.
    function automatic sndc_pkg::out_item_t predict_element(sndc_pkg::in_item_t it);
        sndc_pkg::out_item_t r;
        logic [63:0] so, dof;
        int unsigned eb;
        bit done;
        int i;
        r = '0;
        if (it.cmd == sndc_pkg::CMD_LOAD)
        begin
            pr_extent[it.dim_index]  = it.extent;
            pr_sstride[it.dim_index] = it.src_step;
            pr_dstride[it.dim_index] = it.dst_step;
        end
        else if (it.cmd == sndc_pkg::CMD_START)
        begin
            if (it.src_rank != it.dst_rank)
            begin
                if (pr_refusals == 0)
                begin
                    pr_bad_src = it.src_rank;
                    pr_bad_dst = it.dst_rank;
                end
                if (pr_refusals != '1)
                    pr_refusals++;
                pr_active = 1'b0;
                r.refused = 1'b1;
            end
            else
            begin
                eb = it.elem_bytes;
                if (eb == 0)
                    eb = 1;
                if (eb > 64)
                    eb = 64;
                pr_eb = sndc_pkg::EB_W'(eb);
                pr_rank = (it.src_rank > sndc_pkg::MAX_RANK) ? sndc_pkg::MAX_RANK
                                                             : it.src_rank;
                pr_src_start = it.src_base +
                    sndc_pkg::ADDR_WIDTH'(64'(signed'(it.src_offset)) * eb);
                pr_dst_start = it.dst_base +
                    sndc_pkg::ADDR_WIDTH'(64'(signed'(it.dst_offset)) * eb);
                pr_active = 1'b1;
                for (i = 0; i < sndc_pkg::MAX_RANK; i++)
                begin
                    pr_counter[i] = '0;
                    if (i < pr_rank && pr_extent[i] == 0)
                        pr_active = 1'b0;
                end
            end
        end
        else if (it.cmd == sndc_pkg::CMD_NEXT && pr_active)
        begin
            so = '0;
            dof = '0;
            for (i = 0; i < pr_rank; i++)
            begin
                so  += 64'(pr_counter[i]) * 64'(signed'(pr_sstride[i]));
                dof += 64'(pr_counter[i]) * 64'(signed'(pr_dstride[i]));
            end
            r.element_valid = 1'b1;
            r.src_addr = pr_src_start + sndc_pkg::ADDR_WIDTH'(so * pr_eb);
            r.dst_addr = pr_dst_start + sndc_pkg::ADDR_WIDTH'(dof * pr_eb);
            done = 1'b1;
            for (i = int'(pr_rank) - 1; i >= 0; i--)
            begin
                if (33'(pr_counter[i]) + 1 < 33'(pr_extent[i]))
                begin
                    pr_counter[i]++;
                    done = 1'b0;
                    break;
                end
                pr_counter[i] = '0;
            end
            if (done)
            begin
                r.last = 1'b1;
                pr_active = 1'b0;
            end
        end
        r.copy_bytes = pr_eb;
        r.mismatch_count = pr_refusals;
        r.first_bad_src_rank = pr_bad_src;
        r.first_bad_dst_rank = pr_bad_dst;
        return r;
    endfunction

    // Offers one transaction, waits for acceptance and queues its expectation.
    // Valid stays high after acceptance unless the sender idles.
    task automatic send_item(sndc_pkg::in_item_t it);
        while (tx_idle_ok && $urandom_range(99) < 19)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_results.push_back(predict_element(it));
    endtask

    function automatic sndc_pkg::in_item_t rand_fields();
        sndc_pkg::in_item_t it;
        logic [9*32-1:0]    raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom};
        it = raw[$bits(sndc_pkg::in_item_t)-1:0];
        return it;
    endfunction

    function automatic sndc_pkg::in_item_t mk_load(int d, logic [31:0] e, logic [31:0] s,
                                                   logic [31:0] t);
        sndc_pkg::in_item_t it;
        it = rand_fields();
        it.cmd = sndc_pkg::CMD_LOAD;
        it.dim_index = sndc_pkg::DIM_W'(d);
        it.extent = e;
        it.src_step = s;
        it.dst_step = t;
        return it;
    endfunction

    function automatic sndc_pkg::in_item_t mk_start(int sr, int dr, logic [47:0] sb,
                                                    logic [47:0] db, logic [31:0] so,
                                                    logic [31:0] dof, int eb);
        sndc_pkg::in_item_t it;
        it = rand_fields();
        it.cmd = sndc_pkg::CMD_START;
        it.src_rank = sndc_pkg::RANK_W'(sr);
        it.dst_rank = sndc_pkg::RANK_W'(dr);
        it.src_base = sb;
        it.dst_base = db;
        it.src_offset = so;
        it.dst_offset = dof;
        it.elem_bytes = sndc_pkg::EB_W'(eb);
        return it;
    endfunction

    function automatic sndc_pkg::in_item_t mk_next();
        sndc_pkg::in_item_t it;
        it = rand_fields();
        it.cmd = sndc_pkg::CMD_NEXT;
        return it;
    endfunction

    // Directed table entry; a check value is used only where has_check is set.
    typedef struct {
        sndc_pkg::in_item_t  item;
        bit                  has_check;
        sndc_pkg::out_item_t check;
    } dir_row_t;

    // Output side: random stalls, one long hold and the comparison.
    always @(posedge clk)
    begin
        if (rx_long_hold)
            out_ready <= 1'b0;
        else
            out_ready <= !(rx_idle_ok && $urandom_range(99) < 19);
        if (out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with none expected: %p", $time, out_data);
                errors++;
            end
            else
            begin
                sndc_pkg::out_item_t e;
                e = expected_results.pop_front();
                if (e !== out_data)
                begin
                    $display("%0t: mismatch expected %p actual %p", $time, e, out_data);
                    errors++;
                end
            end
        end
    end

    // Long receiver hold counted in its own process.
    initial
    begin
        int n;
        wait (rst_n);
        repeat (300) @(posedge clk);
        rx_long_hold = 1'b1;
        for (n = 0; n < 200; n++)
            @(posedge clk);
        rx_long_hold = 1'b0;
    end

    // Random copy with well-formed loads; small extents keep copies short.
    task automatic random_copy(inout int count);
        int r, i, nn, sr, dr;
        logic [31:0] ext;
        r = $urandom_range(0, 4);
        if ($urandom_range(9) == 0)
            r = $urandom_range(5, 16);
        for (i = 0; i < r; i++)
        begin
            ext = $urandom_range(1, (r > 4) ? 1 : 4);
            if ($urandom_range(19) == 0)
                ext = 0;
            if ($urandom_range(49) == 0 && r == 1)
                ext = 32'hFFFF_FFFF;
            send_item(mk_load(i, ext, $urandom, $urandom));
            count++;
        end
        if ($urandom_range(9) == 0)
        begin
            // Refused start: the ranks are forced to differ.
            sr = $urandom_range(31);
            dr = $urandom_range(31);
            if (dr == sr)
                dr = (sr + 1) % 32;
            send_item(mk_start(sr, dr, 48'($urandom), 48'($urandom),
                               $urandom, $urandom, $urandom));
        end
        else
        begin
            nn = (r == 16 && $urandom_range(1)) ? $urandom_range(16, 31) : r;
            send_item(mk_start(nn, nn, 48'({$urandom, $urandom}),
                               48'({$urandom, $urandom}),
                               $urandom, $urandom, $urandom));
        end
        count++;
        nn = $urandom_range(1, 12);
        for (i = 0; i < nn; i++)
        begin
            if ($urandom_range(19) == 0 && r > 0)
                send_item(mk_load($urandom_range(r - 1), $urandom_range(0, 4),
                                  $urandom, $urandom));
            else if ($urandom_range(29) == 0)
                send_item(mk_load($urandom_range(0, 3), $urandom_range(1, 3),
                                  $urandom, $urandom));
            else if ($urandom_range(29) == 0)
            begin
                sndc_pkg::in_item_t it;
                it = rand_fields();
                it.cmd = 2'd3;
                send_item(it);
            end
            else
                send_item(mk_next());
            count++;
        end
    endtask

    // Main stimulus: directed table, then random copies, then drain.
    initial
    begin
        dir_row_t            rows[$];
        dir_row_t            row;
        sndc_pkg::out_item_t idle_res;
        int k, count, guard;
        for (k = 0; k < sndc_pkg::MAX_RANK; k++)
        begin
            pr_extent[k] = '0; pr_sstride[k] = '0; pr_dstride[k] = '0;
            pr_counter[k] = '0;
        end
        pr_src_start = '0; pr_dst_start = '0; pr_rank = 0; pr_eb = 1;
        pr_active = 1'b0; pr_refusals = '0; pr_bad_src = '0; pr_bad_dst = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_res = '0;
        idle_res.copy_bytes = 1;
        // Next with no copy after reset: empty result.
        row.item = mk_next(); row.has_check = 1; row.check = idle_res; rows.push_back(row);
        // Rank mismatch: refused, counter one, ranks kept.
        row.item = mk_start(3, 5, '0, '0, 0, 0, 8); row.has_check = 1;
        row.check = idle_res; row.check.refused = 1; row.check.mismatch_count = 1;
        row.check.first_bad_src_rank = 3; row.check.first_bad_dst_rank = 5;
        rows.push_back(row);
        row.has_check = 0;
        // Second refusal keeps the first ranks.
        row.item = mk_start(16, 0, '0, '0, 0, 0, 1); rows.push_back(row);
        // Rank zero gives one element; maximal base and element size clamp.
        row.item = mk_start(0, 0, '1, '1, 32'h7FFF_FFFF, 32'h8000_0000, 127);
        rows.push_back(row);
        row.item = mk_next(); rows.push_back(row);
        row.item = mk_next(); rows.push_back(row);
        // Extremes of loads.
        row.item = mk_load(0, 2, 32'h8000_0000, 32'h7FFF_FFFF); rows.push_back(row);
        row.item = mk_load(1, 3, 32'hFFFF_FFFF, 1); rows.push_back(row);
        row.item = mk_load(15, 32'hFFFF_FFFF, 0, 0); rows.push_back(row);
        row.item = mk_start(2, 2, 48'h1000, 48'hFFFF_FFFF_FFF0, -1, 5, 0);
        rows.push_back(row);
        for (k = 0; k < 4; k++)
        begin
            row.item = mk_next(); rows.push_back(row);
        end
        // Load during the copy, then a start replacing the copy.
        row.item = mk_load(1, 1, 7, -7); rows.push_back(row);
        row.item = mk_next(); rows.push_back(row);
        row.item = mk_start(2, 2, 48'h0, 48'h0, 0, 0, 64); rows.push_back(row);
        row.item = mk_next(); rows.push_back(row);
        // Zero extent: no element.
        row.item = mk_load(0, 0, 1, 1); rows.push_back(row);
        row.item = mk_start(1, 1, 0, 0, 0, 0, 4); rows.push_back(row);
        row.item = mk_next(); rows.push_back(row);
        // Unknown command and a load out of use.
        row.item = rand_fields(); row.item.cmd = 2'd3; rows.push_back(row);
        row.item = mk_load(0, 1, 1, 1); rows.push_back(row);
        for (k = 0; k < rows.size(); k++)
        begin
            send_item(rows[k].item);
            if (rows[k].has_check)
                expected_results[expected_results.size() - 1] = rows[k].check;
        end

        count = 0;
        while (count < 1250)
        begin
            if (count > 400 && count < 700)
            begin
                tx_idle_ok = 1'b0;
                rx_idle_ok = 1'b0;
            end
            else
            begin
                tx_idle_ok = 1'b1;
                rx_idle_ok = 1'b1;
            end
            if (count > 800 && count < 830 && expected_results.size() != 0)
            begin
                // Pause the sender until everything has come back.
                in_valid <= 1'b0;
                while (expected_results.size() != 0)
                    @(posedge clk);
            end
            random_copy(count);
        end
        in_valid <= 1'b0;
        guard = 0;
        while (expected_results.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end
endmodule
